// ===== rtl/icmp_echo_reply_checker_core_macros.svh =====
// Assertion macros shared by the checker RTL.
`ifndef ICMP_ECHO_REPLY_CHECKER_CORE_MACROS_SVH
`define ICMP_ECHO_REPLY_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/icmp_chk_pkg.sv =====
// Package with request/response types and status codes of the ICMP echo reply checker.
`timescale 1ns / 1ps

package icmp_chk_pkg;

    // Status codes reported with every response.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TYPE_BAD = 2'd1;
    localparam logic [1:0] ST_CSUM_BAD = 2'd2;
    localparam logic [1:0] ST_LEN_BAD  = 2'd3;

    // One received packet byte.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       final_byte;
    } chk_req_t;

    // One parsed echo reply with its status.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  reply_code;
        logic [15:0] echo_ident;
        logic [15:0] echo_sequence;
        logic [31:0] echo_payload;
    } chk_rsp_t;

endpackage

// ===== rtl/icmp_echo_reply_checker_core.sv =====
// Top level of the ICMP echo reply checker: byte parser, checksum and response register.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries one packet byte
//   per request; final_byte marks the last byte of a packet. When the
//   ip_header_present register is 1, the first byte's low nibble N makes the
//   block drop (4*N-1) mod 256 further bytes before the 12-byte echo reply.
//   The response channel (rsp_valid, rsp_stall, rsp_data) gives one response per
//   packet, on its final byte, with the parsed fields and a status code.
//   The configuration channel (cfg_valid, cfg_ready, cfg_data) writes
//   ip_header_present; it is always ready. The user must write it only while
//   idle; the block does not enforce this. A final byte waits in the input
//   register, and its response is registered once the response register is
//   free. One byte per cycle, while req_stall is low, enters the single input
//   register feeding the parse and checksum logic. Reset clears the parse state
//   and both valid flags and sets ip_header_present to 1. While a response
//   waits under rsp_stall, non-final bytes still flow; a final byte waits in the
//   input register and then req_stall rises until the response register frees.
`timescale 1ns / 1ps
`include "icmp_echo_reply_checker_core_macros.svh"

module icmp_echo_reply_checker_core
    import icmp_chk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  chk_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output chk_rsp_t rsp_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    localparam logic [8:0] POS_MAX = 9'h1FF;

    // ICMP byte offsets of each field.
    localparam logic [8:0] OFF_TYPE      = 9'd0;
    localparam logic [8:0] OFF_CODE      = 9'd1;
    localparam logic [8:0] OFF_CSUM_END  = 9'd3;
    localparam logic [8:0] OFF_IDENT_END = 9'd5;
    localparam logic [8:0] OFF_SEQ_END   = 9'd7;
    localparam logic [8:0] OFF_LAST      = 9'd11;

    // Configuration and input stage registers.
    logic     hdr_reg;
    logic     s1_valid_reg;
    chk_req_t s1_req_reg;

    // Per-packet parse state.
    logic [8:0]  pos_reg,   pos_next;
    logic [7:0]  skip_reg,  skip_next;
    logic        tbad_reg,  tbad_next;
    logic [7:0]  code_reg,  code_next;
    logic [15:0] csum_reg,  csum_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] seq_reg,   seq_next;
    logic [31:0] pay_reg,   pay_next;

    // Response register.
    logic     rsp_valid_reg;
    chk_rsp_t rsp_reg, rsp_next;

    logic        out_free;
    logic        s1_fire;
    logic        s1_fire_final;
    logic        is_icmp;
    logic [8:0]  off;
    logic [18:0] sum_raw;
    logic [16:0] sum_fold;
    logic [15:0] sum_wrap;
    logic [15:0] csum_expected;

    // Handshake: non-final bytes always proceed, a final byte needs a free response slot.
    assign out_free      = !rsp_valid_reg || !rsp_stall;
    assign s1_fire       = s1_valid_reg && (!s1_req_reg.final_byte || out_free);
    assign s1_fire_final = s1_fire && s1_req_reg.final_byte;
    assign req_stall     = s1_valid_reg && !s1_fire;
    assign cfg_ready     = 1'b1;
    assign rsp_valid     = rsp_valid_reg;
    assign rsp_data      = rsp_reg;

    // Byte parser: header skip, then field assembly by ICMP offset.
    always_comb
    begin
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        tbad_next  = tbad_reg;
        code_next  = code_reg;
        csum_next  = csum_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        pay_next   = pay_reg;
        is_icmp    = 1'b0;
        off        = '0;
        if (skip_reg != 8'd0)
        begin
            skip_next = skip_reg - 8'd1;
        end
        else if (hdr_reg && (pos_reg == 9'd0))
        begin
            skip_next = {2'b00, s1_req_reg.rx_byte[3:0], 2'b00} - 8'd1;
            pos_next  = 9'd1;
        end
        else
        begin
            is_icmp = 1'b1;
            off     = pos_reg - {8'd0, hdr_reg};
            if (off == OFF_TYPE)
            begin
                tbad_next = (s1_req_reg.rx_byte != 8'd0);
            end
            else if (off == OFF_CODE)
            begin
                code_next = s1_req_reg.rx_byte;
            end
            else if (off <= OFF_CSUM_END)
            begin
                csum_next = {csum_reg[7:0], s1_req_reg.rx_byte};
            end
            else if (off <= OFF_IDENT_END)
            begin
                ident_next = {ident_reg[7:0], s1_req_reg.rx_byte};
            end
            else if (off <= OFF_SEQ_END)
            begin
                seq_next = {seq_reg[7:0], s1_req_reg.rx_byte};
            end
            else if (off <= OFF_LAST)
            begin
                pay_next = {pay_reg[23:0], s1_req_reg.rx_byte};
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    // Ones' complement checksum over the assembled words, folded twice.
    always_comb
    begin
        sum_raw       = {11'd0, code_next} + {3'd0, ident_next} + {3'd0, seq_next}
                      + {3'd0, pay_next[31:16]} + {3'd0, pay_next[15:0]};
        sum_fold      = {14'd0, sum_raw[18:16]} + {1'b0, sum_raw[15:0]};
        sum_wrap      = sum_fold[15:0] + {15'd0, sum_fold[16]};
        csum_expected = ~sum_wrap;
    end

    // Response fields and status, by priority.
    always_comb
    begin
        rsp_next.reply_code    = code_next;
        rsp_next.echo_ident    = ident_next;
        rsp_next.echo_sequence = seq_next;
        rsp_next.echo_payload  = pay_next;
        priority if (tbad_next)
        begin
            rsp_next.status = ST_TYPE_BAD;
        end
        else if (!(is_icmp && (off == OFF_LAST)))
        begin
            rsp_next.status = ST_LEN_BAD;
        end
        else if (csum_expected != csum_next)
        begin
            rsp_next.status = ST_CSUM_BAD;
        end
        else
        begin
            rsp_next.status = ST_OK;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hdr_reg <= cfg_data;
        end
    end

    // Input stage: takes a request whenever the held one moves on or none is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_req_reg <= req_data;
        end
    end

    // Parse state: updated per byte, cleared after a final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            skip_reg  <= '0;
            tbad_reg  <= 1'b0;
            code_reg  <= '0;
            csum_reg  <= '0;
            ident_reg <= '0;
            seq_reg   <= '0;
            pay_reg   <= '0;
        end
        else if (s1_fire_final)
        begin
            pos_reg   <= '0;
            skip_reg  <= '0;
            tbad_reg  <= 1'b0;
            code_reg  <= '0;
            csum_reg  <= '0;
            ident_reg <= '0;
            seq_reg   <= '0;
            pay_reg   <= '0;
        end
        else if (s1_fire)
        begin
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            tbad_reg  <= tbad_next;
            code_reg  <= code_next;
            csum_reg  <= csum_next;
            ident_reg <= ident_next;
            seq_reg   <= seq_next;
            pay_reg   <= pay_next;
        end
    end

    // Response register: loaded on a final byte, released when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_fire_final)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire_final)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Assertions on the parser and response path.
    `CHK_ASSERT_IMP(a_nonfinal_flows, clk, rst_n,
        s1_valid_reg && !s1_req_reg.final_byte, s1_fire)
    `CHK_ASSERT_NXT(a_final_clears, clk, rst_n,
        s1_fire_final, rsp_valid_reg && (pos_reg == 9'd0) && (skip_reg == 8'd0))
    `CHK_ASSERT_NXT(a_skip_counts, clk, rst_n,
        s1_fire && !s1_req_reg.final_byte && (skip_reg != 8'd0),
        skip_reg == $past(skip_reg) - 8'd1)
    `CHK_ASSERT_NXT(a_type_first, clk, rst_n,
        s1_fire_final && tbad_next, rsp_reg.status == ST_TYPE_BAD)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ICMP echo reply checker core.
`timescale 1ns / 1ps

module testbench;
    import icmp_chk_pkg::*;

    // Clock, reset and block ports.
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    chk_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    chk_rsp_t rsp_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_data  = 1'b0;

    // Bytes waiting to be sent and responses still owed by the block.
    chk_req_t pending_bytes[$];
    chk_rsp_t expected_replies[$];

    // Idle percentages of the current phase, and the header mode of the generator.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          gen_hdr        = 1'b1;

    // Run statistics.
    int mismatches     = 0;
    int bytes_queued   = 0;
    int packets_queued = 0;
    int replies_seen   = 0;
    int status_count[4];

    // Predictor copy of the parser state and the header register.
    bit          hdr_on;
    logic [8:0]  pos_q;
    logic [7:0]  skip_left;
    bit          type_err;
    logic [7:0]  code_q;
    logic [15:0] csum_rx;
    logic [15:0] ident_q;
    logic [15:0] seq_q;
    logic [31:0] data_q;

    icmp_echo_reply_checker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Ones' complement checksum over code, identifier, sequence and data.
    function automatic logic [15:0] echo_csum(input logic [7:0] code, input logic [15:0] ident,
                                              input logic [15:0] seq, input logic [31:0] data);
        logic [31:0] sum;
        sum = {24'd0, code} + {16'd0, ident} + {16'd0, seq}
            + {16'd0, data[31:16]} + {16'd0, data[15:0]};
        sum = (sum >> 16) + (sum & 32'hFFFF);
        sum = sum + (sum >> 16);
        return ~sum[15:0];
    endfunction

    task automatic clear_parse();
        pos_q     = '0;
        skip_left = '0;
        type_err  = 1'b0;
        code_q    = '0;
        csum_rx   = '0;
        ident_q   = '0;
        seq_q     = '0;
        data_q    = '0;
    endtask

    // Advance the predicted parser by one byte; a final byte yields a response.
    task automatic parse_byte(input chk_req_t r, output bit produced, output chk_rsp_t reply);
        bit         is_icmp;
        logic [8:0] idx;
        is_icmp  = 1'b0;
        idx      = '0;
        produced = 1'b0;
        reply    = '0;
        if (skip_left != 0) begin
            skip_left = skip_left - 8'd1;
        end else if (hdr_on && pos_q == 0) begin
            skip_left = {2'b00, r.rx_byte[3:0], 2'b00} - 8'd1;
            pos_q     = 9'd1;
        end else begin
            is_icmp = 1'b1;
            idx     = pos_q - (hdr_on ? 9'd1 : 9'd0);
            if (idx == 0)
                type_err = (r.rx_byte != 8'd0);
            else if (idx == 1)
                code_q = r.rx_byte;
            else if (idx <= 3)
                csum_rx = {csum_rx[7:0], r.rx_byte};
            else if (idx <= 5)
                ident_q = {ident_q[7:0], r.rx_byte};
            else if (idx <= 7)
                seq_q = {seq_q[7:0], r.rx_byte};
            else if (idx <= 11)
                data_q = {data_q[23:0], r.rx_byte};
            if (pos_q != 9'd511)
                pos_q = pos_q + 9'd1;
        end
        if (r.final_byte) begin
            produced = 1'b1;
            // Type error wins over length, which wins over checksum.
            if (type_err)
                reply.status = ST_TYPE_BAD;
            else if (!(is_icmp && idx == 11))
                reply.status = ST_LEN_BAD;
            else if (echo_csum(code_q, ident_q, seq_q, data_q) != csum_rx)
                reply.status = ST_CSUM_BAD;
            else
                reply.status = ST_OK;
            reply.reply_code    = code_q;
            reply.echo_ident    = ident_q;
            reply.echo_sequence = seq_q;
            reply.echo_payload  = data_q;
            clear_parse();
        end
    endtask

    // Request driver: launches the next byte whenever the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req_data  <= pending_bytes.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Response backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: tracks register writes, predicts from accepted bytes, checks responses.
    always @(posedge clk or negedge rst_n)
    begin
        bit       produced;
        chk_rsp_t reply;
        chk_rsp_t want;
        if (!rst_n)
        begin
            hdr_on = 1'b1;
            clear_parse();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                hdr_on = cfg_data;
            if (req_valid && !req_stall)
            begin
                parse_byte(req_data, produced, reply);
                if (produced)
                begin
                    expected_replies = {expected_replies, reply};
                    status_count[reply.status]++;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response %p", $realtime, rsp_data);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_data.status !== want.status
                        || rsp_data.reply_code !== want.reply_code
                        || rsp_data.echo_ident !== want.echo_ident
                        || rsp_data.echo_sequence !== want.echo_sequence
                        || rsp_data.echo_payload !== want.echo_payload)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: response mismatch, expected %p, got %p",
                                     $realtime, want, rsp_data);
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit fin);
        chk_req_t r;
        r.rx_byte    = b;
        r.final_byte = fin;
        pending_bytes = {pending_bytes, r};
        bytes_queued++;
        if (fin)
            packets_queued++;
    endtask

    // Build one packet: optional header, echo reply, then perhaps cut short or padded.
    // A nonzero tail forces that many trailing bytes after the reply.
    task automatic add_packet(input int nib, input int tail);
        logic [7:0]  pkt[$];
        logic [7:0]  code;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [15:0] csum;
        logic [31:0] data;
        int          kind;
        int          cut;
        code  = 8'($urandom);
        ident = 16'($urandom);
        seq   = 16'($urandom);
        data  = $urandom;
        csum  = echo_csum(code, ident, seq, data);
        if ($urandom_range(9) == 0)
            csum = csum ^ 16'($urandom_range(1, 65535));
        if (gen_hdr)
        begin
            pkt = {pkt, {4'($urandom_range(15)), 4'(nib)}};
            repeat ((nib * 4 - 1) & 255) pkt = {pkt, 8'($urandom_range(255))};
        end
        pkt = {pkt, (($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0)};
        pkt = {pkt, code};
        pkt = {pkt, csum[15:8]};
        pkt = {pkt, csum[7:0]};
        pkt = {pkt, ident[15:8]};
        pkt = {pkt, ident[7:0]};
        pkt = {pkt, seq[15:8]};
        pkt = {pkt, seq[7:0]};
        pkt = {pkt, data[31:24]};
        pkt = {pkt, data[23:16]};
        pkt = {pkt, data[15:8]};
        pkt = {pkt, data[7:0]};
        kind = $urandom_range(9);
        if (tail > 0)
        begin
            repeat (tail) pkt = {pkt, 8'($urandom_range(255))};
        end
        else if (kind == 0)
        begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        else if (kind == 1)
        begin
            repeat ($urandom_range(1, 6)) pkt = {pkt, 8'($urandom_range(255))};
        end
        foreach (pkt[i])
            push_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Hold the sender until all bytes are taken and every response has come back.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || req_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_hdr(input bit value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_hdr = value;
    endtask

    // Stimulus: directed packets, then four random phases with different idling.
    initial
    begin
        int phase;
        int start;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header mode from reset: final byte on the header itself, and inside the skip.
        push_byte(8'h45, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'hAA, 1'b1);
        wait_idle();

        // No header: a good reply with extreme fields, a bad type, a lone type byte.
        write_hdr(1'b0);
        begin
            logic [15:0] c;
            c = echo_csum(8'hFF, 16'hFFFF, 16'h0000, 32'hFFFF0000);
            push_byte(8'h00, 1'b0);
            push_byte(8'hFF, 1'b0);
            push_byte(c[15:8], 1'b0);
            push_byte(c[7:0], 1'b0);
            push_byte(8'hFF, 1'b0);
            push_byte(8'hFF, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(8'hFF, 1'b0);
            push_byte(8'hFF, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(8'h00, 1'b1);
        end
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);

        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            write_hdr(phase % 2 == 0);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            start = bytes_queued;
            // A zero header nibble drops 255 bytes; a very long packet saturates the position.
            if (phase == 0)
                add_packet(0, 0);
            if (phase == 1)
                add_packet(5, 520);
            while (bytes_queued - start < 350)
                add_packet(($urandom_range(3) != 0) ? 5 : $urandom_range(1, 15), 0);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_replies.size() != 0)
            mismatches++;
        $display("Sent %0d bytes in %0d packets, both header modes, four idle phases.",
                 bytes_queued, packets_queued);
        $display("Checked %0d responses: ok %0d, bad type %0d, bad checksum %0d, bad length %0d.",
                 replies_seen, status_count[ST_OK], status_count[ST_TYPE_BAD],
                 status_count[ST_CSUM_BAD], status_count[ST_LEN_BAD]);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
